// ===== rtl/psar_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psar_pkg
// Shared widths, codes and controller/datapath types of the process scheduler.
// ----------------------------------------------------------------------------
package psar_pkg;

  // request and result field widths
  localparam int CMD_W        = 2;
  localparam int SLOT_FIELD_W = 6;
  localparam int PRIO_FIELD_W = 8;
  localparam int TIME_FIELD_W = 16;
  localparam int STATUS_W     = 2;

  // default sizing
  localparam int DEF_SLOTS     = 64;
  localparam int DEF_PRIO_BITS = 8;
  localparam int DEF_TIME_BITS = 16;

  // apb register file
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam logic REG_MODE_IDX = 1'b0;

  // scheduler mode
  localparam logic MODE_PRIO  = 1'b0;
  localparam logic MODE_RR    = 1'b1;
  localparam logic MODE_RESET = MODE_RR;

  // commands
  localparam logic [CMD_W-1:0] CMD_TICK   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_EXIT   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CREATE = 2'd2;
  localparam logic [CMD_W-1:0] CMD_KILL   = 2'd3;

  // result status
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NONE    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_USE = 2'd3;

  typedef struct packed {
    logic load;
    logic clr_cur;
    logic scan_clr;
    logic find_step;
    logic sel;
    logic res_none;
    logic rr_clr;
    logic rr_step;
    logic fetch_best;
    logic rr_fin;
    logic scan_step;
    logic create_hit;
    logic create_grow;
    logic res_full;
    logic fetch_tgt;
    logic kill_fin;
    logic res_not_use;
    logic push;
  } psar_cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0] req_cmd;
    logic             kill_ok;
    logic             scan_idle;
    logic             found;
    logic             rr_hit;
    logic             rr_end;
    logic             c_hit;
    logic             c_end;
    logic             full;
    logic             out_free;
  } psar_stat_t;

endpackage

// ===== rtl/psar_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psar_if
// Valid/ready channels for scheduler requests and results.
// ----------------------------------------------------------------------------
interface psar_in_if import psar_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [CMD_W-1:0]        command;
  logic [SLOT_FIELD_W-1:0] target_slot;
  logic [PRIO_FIELD_W-1:0] new_priority;
  logic [TIME_FIELD_W-1:0] new_arrival;

  modport source (output valid, command, target_slot, new_priority, new_arrival,
                  input ready);
  modport sink (input valid, command, target_slot, new_priority, new_arrival,
                output ready);
endinterface

interface psar_out_if import psar_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [SLOT_FIELD_W-1:0] chosen_slot;
  logic [PRIO_FIELD_W-1:0] chosen_priority;
  logic [STATUS_W-1:0]     status;

  modport source (output valid, chosen_slot, chosen_priority, status,
                  input ready);
  modport sink (input valid, chosen_slot, chosen_priority, status,
                output ready);
endinterface

// ===== rtl/psar_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psar_ctrl
// Sequencer for decode, table scans, single fetches and result hand-off.
// ----------------------------------------------------------------------------
module psar_ctrl import psar_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       mode,
  input  psar_stat_t stat,
  output psar_cmd_t  cmd
);

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_DECODE    = 4'd1;
  localparam logic [3:0] S_FIND      = 4'd2;
  localparam logic [3:0] S_SEL       = 4'd3;
  localparam logic [3:0] S_RR        = 4'd4;
  localparam logic [3:0] S_RR_FETCH  = 4'd5;
  localparam logic [3:0] S_RR_FIN    = 4'd6;
  localparam logic [3:0] S_CREATE    = 4'd7;
  localparam logic [3:0] S_KILL_FIN  = 4'd8;
  localparam logic [3:0] S_OUT       = 4'd9;

  logic [3:0] state;
  logic [3:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    in_ready   = 1'b0;
    state_next = state;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        case (stat.req_cmd)
          CMD_TICK, CMD_EXIT: begin
            cmd.clr_cur = (stat.req_cmd == CMD_EXIT);
            if (mode == MODE_PRIO) begin
              cmd.scan_clr = 1'b1;
              state_next   = S_FIND;
            end else begin
              cmd.rr_clr = 1'b1;
              state_next = S_RR;
            end
          end
          CMD_CREATE: begin
            cmd.scan_clr = 1'b1;
            state_next   = S_CREATE;
          end
          default: begin
            if (stat.kill_ok) begin
              cmd.fetch_tgt = 1'b1;
              state_next    = S_KILL_FIN;
            end else begin
              cmd.res_not_use = 1'b1;
              state_next      = S_OUT;
            end
          end
        endcase
      end
      S_FIND: begin
        cmd.find_step = 1'b1;
        if (stat.scan_idle) begin
          state_next = S_SEL;
        end
      end
      S_SEL: begin
        cmd.sel      = stat.found;
        cmd.res_none = !stat.found;
        state_next   = S_OUT;
      end
      S_RR: begin
        if (stat.rr_end) begin
          cmd.res_none = 1'b1;
          state_next   = S_OUT;
        end else begin
          cmd.rr_step = 1'b1;
          if (stat.rr_hit) begin
            state_next = S_RR_FETCH;
          end
        end
      end
      S_RR_FETCH: begin
        cmd.fetch_best = 1'b1;
        state_next     = S_RR_FIN;
      end
      S_RR_FIN: begin
        cmd.rr_fin = 1'b1;
        state_next = S_OUT;
      end
      S_CREATE: begin
        if (stat.c_hit) begin
          cmd.create_hit = 1'b1;
          state_next     = S_OUT;
        end else if (stat.c_end) begin
          cmd.res_full    = stat.full;
          cmd.create_grow = !stat.full;
          state_next      = S_OUT;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_KILL_FIN: begin
        cmd.kill_fin = 1'b1;
        state_next   = S_OUT;
      end
      S_OUT: begin
        if (stat.out_free) begin
          cmd.push   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/psar_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psar_dp
// Slot table, scan counters, best-slot tracker and result registers.
// ----------------------------------------------------------------------------
module psar_dp import psar_pkg::*; #(
  parameter int SLOTS     = DEF_SLOTS,
  parameter int PRIO_BITS = DEF_PRIO_BITS,
  parameter int TIME_BITS = DEF_TIME_BITS
) (
  input  logic                    clk,
  input  logic                    rst,
  input  psar_cmd_t               cmd,
  output psar_stat_t              stat,
  input  logic [CMD_W-1:0]        command,
  input  logic [SLOT_FIELD_W-1:0] target_slot,
  input  logic [PRIO_FIELD_W-1:0] new_priority,
  input  logic [TIME_FIELD_W-1:0] new_arrival,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [SLOT_FIELD_W-1:0] chosen_slot,
  output logic [PRIO_FIELD_W-1:0] chosen_priority,
  output logic [STATUS_W-1:0]     status
);

  localparam int SW         = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW         = $clog2(SLOTS + 1);
  localparam int WW         = PRIO_BITS + TIME_BITS;
  localparam int CMPW       = (CW > SLOT_FIELD_W) ? CW : SLOT_FIELD_W;
  localparam int RESET_USED = (SLOTS < 3) ? SLOTS : 3;
  localparam logic [PRIO_BITS-1:0] PRIO_MAX = {PRIO_BITS{1'b1}};

  // latched request
  logic [CMD_W-1:0]        req_cmd;
  logic [SLOT_FIELD_W-1:0] req_tgt;
  logic [PRIO_BITS-1:0]    req_prio;
  logic [TIME_BITS-1:0]    req_arr;

  // slot table
  logic [SLOTS-1:0] valid;
  logic [SLOTS-1:0] init;
  logic [WW-1:0]    mem [SLOTS];

  logic [CW-1:0] used;
  logic [SW-1:0] cur;
  logic [CW-1:0] scan_idx;
  logic [SW-1:0] rr_idx;

  logic                 found;
  logic [SW-1:0]        best_idx;
  logic [PRIO_BITS-1:0] best_prio;
  logic [TIME_BITS-1:0] best_arr;

  // read pipeline
  logic [WW-1:0] rd_data;
  logic          rd_init;
  logic          rd_vld;
  logic [SW-1:0] rd_idx;

  logic [SW-1:0]        res_idx;
  logic [PRIO_BITS-1:0] res_prio;
  logic [STATUS_W-1:0]  res_status;

  logic                 scan_live;
  logic                 find_issue;
  logic                 proc_en;
  logic                 better;
  logic                 age_en;
  logic [PRIO_BITS-1:0] rd_prio;
  logic [TIME_BITS-1:0] rd_arr;
  logic [SW-1:0]        tgt_idx;
  logic [SW-1:0]        scan_slot;
  logic [SW-1:0]        rr_cand;
  logic [SW-1:0]        rd_addr;
  logic                 rd_en;
  logic                 wr_en;
  logic [SW-1:0]        wr_addr;
  logic [WW-1:0]        wr_data;
  logic                 create_en;

  assign rd_prio   = rd_init ? rd_data[WW-1:TIME_BITS] : '0;
  assign rd_arr    = rd_init ? rd_data[TIME_BITS-1:0] : '0;
  assign tgt_idx   = SW'(req_tgt);
  assign scan_slot = scan_idx[SW-1:0];
  assign scan_live = (scan_idx < used);
  assign rr_cand   = ((CW'(rr_idx) + CW'(1)) >= used) ? '0 : (rr_idx + SW'(1));

  assign find_issue = cmd.find_step && scan_live;
  assign proc_en    = cmd.find_step && rd_vld && valid[rd_idx];
  assign better     = !found || (rd_prio > best_prio) ||
                      ((rd_prio == best_prio) && (rd_arr < best_arr));
  assign age_en     = proc_en && (rd_prio != PRIO_MAX);
  assign create_en  = cmd.create_hit || cmd.create_grow;

  assign rd_en   = find_issue || cmd.fetch_best || cmd.fetch_tgt;
  assign rd_addr = cmd.fetch_best ? rr_idx : (cmd.fetch_tgt ? tgt_idx : scan_slot);

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = rd_idx;
    wr_data = {rd_prio + PRIO_BITS'(1), rd_arr};
    if (cmd.sel) begin
      wr_en   = 1'b1;
      wr_addr = best_idx;
      wr_data = {best_prio, best_arr};
    end else if (create_en) begin
      wr_en   = 1'b1;
      wr_addr = cmd.create_hit ? scan_slot : used[SW-1:0];
      wr_data = {req_prio, req_arr};
    end else if (age_en) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
      rd_init <= init[rd_addr];
    end
    rd_idx <= scan_slot;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_cmd  <= command;
      req_tgt  <= target_slot;
      req_prio <= PRIO_BITS'(new_priority);
      req_arr  <= TIME_BITS'(new_arrival);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        valid[i] <= (i < RESET_USED);
      end
      init <= '0;
      used <= CW'(RESET_USED);
      cur  <= '0;
    end else begin
      if (wr_en) begin
        init[wr_addr] <= 1'b1;
      end
      if (cmd.clr_cur) begin
        valid[cur] <= 1'b0;
      end
      if (cmd.kill_fin) begin
        valid[tgt_idx] <= 1'b0;
      end
      if (create_en) begin
        valid[wr_addr] <= 1'b1;
      end
      if (cmd.create_grow) begin
        used <= used + CW'(1);
      end
      if (cmd.sel) begin
        cur <= best_idx;
      end
      if (cmd.rr_fin) begin
        cur <= rr_idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx <= '0;
      rd_vld   <= 1'b0;
      found    <= 1'b0;
    end else begin
      rd_vld <= find_issue;
      if (cmd.scan_clr || cmd.rr_clr) begin
        scan_idx <= '0;
      end else if (find_issue || cmd.scan_step || cmd.rr_step) begin
        scan_idx <= scan_idx + CW'(1);
      end
      if (cmd.scan_clr) begin
        found <= 1'b0;
      end else if (proc_en && better) begin
        found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (proc_en && better) begin
      best_idx  <= rd_idx;
      best_prio <= rd_prio;
      best_arr  <= rd_arr;
    end
    if (cmd.rr_clr) begin
      rr_idx <= cur;
    end else if (cmd.rr_step) begin
      rr_idx <= rr_cand;
    end
  end

  // result staging
  always_ff @(posedge clk) begin
    if (cmd.sel) begin
      res_idx    <= best_idx;
      res_prio   <= best_prio;
      res_status <= ST_OK;
    end else if (cmd.rr_fin) begin
      res_idx    <= rr_idx;
      res_prio   <= rd_prio;
      res_status <= ST_OK;
    end else if (create_en) begin
      res_idx    <= wr_addr;
      res_prio   <= req_prio;
      res_status <= ST_OK;
    end else if (cmd.kill_fin) begin
      res_idx    <= tgt_idx;
      res_prio   <= rd_prio;
      res_status <= ST_OK;
    end else if (cmd.res_none || cmd.res_full || cmd.res_not_use) begin
      res_idx    <= '0;
      res_prio   <= '0;
      res_status <= cmd.res_none ? ST_NONE : (cmd.res_full ? ST_FULL : ST_NOT_USE);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      chosen_slot     <= SLOT_FIELD_W'(res_idx);
      chosen_priority <= PRIO_FIELD_W'(res_prio);
      status          <= res_status;
    end
  end

  always_comb begin
    stat.req_cmd   = req_cmd;
    stat.kill_ok   = (CMPW'(req_tgt) < CMPW'(used)) && valid[tgt_idx];
    stat.scan_idle = !scan_live && !rd_vld;
    stat.found     = found;
    stat.rr_hit    = scan_live && valid[rr_cand];
    stat.rr_end    = !scan_live;
    stat.c_hit     = scan_live && !valid[scan_slot];
    stat.c_end     = !scan_live;
    stat.full      = (used == CW'(SLOTS));
    stat.out_free  = !out_valid || out_ready;
  end

  a_used_grows: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> used >= $past(used))
    else $error("slot count shrank");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_OK) |-> (chosen_slot == '0 && chosen_priority == '0))
    else $error("error result carries a slot or priority");

  a_create_marks: assert property (@(posedge clk) disable iff (rst)
    create_en |=> valid[$past(wr_addr)])
    else $error("created slot not marked valid");

  a_kill_frees: assert property (@(posedge clk) disable iff (rst)
    cmd.kill_fin |=> !valid[$past(tgt_idx)])
    else $error("killed slot still valid");

endmodule

// ===== rtl/process_scheduler_aging_rr.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// process_scheduler_aging_rr
// Process slot scheduler with priority aging or round-robin selection.
// ----------------------------------------------------------------------------
// Usage:
//   request channel carries one command (tick, exit, create, kill) per request;
//   result channel returns exactly one result per request, in order.
//   The mode register (APB, byte address 0) selects priority with aging or
//   round robin; write it only while no request is in flight.
//   Work per request, with used = slot high-water count:
//     priority reschedule  scans slots below used (one slot read per cycle, valid slots aged)
//     round-robin resched  steps on from the current slot (one valid bit per cycle)
//     create               first-free search over slots below used
//     kill                 one read of the target slot, none when the slot is not in use
//   One request is worked at a time; the table's single read port and the
//   per-slot scan set the rate. The next request is taken the cycle after the
//   result is handed off to the output register.
//   A new request is taken while a finished result still sits in the output
//   register; if the receiver stalls, the next result waits in the controller
//   until the register frees.
//   Reset: slots 0..2 valid with priority and arrival zero, count three,
//   current slot zero, round-robin mode. No clearing pass is needed.
// ----------------------------------------------------------------------------
module process_scheduler_aging_rr import psar_pkg::*; #(
  parameter int SLOTS     = DEF_SLOTS,
  parameter int PRIO_BITS = DEF_PRIO_BITS,
  parameter int TIME_BITS = DEF_TIME_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  psar_in_if.sink               request,
  psar_out_if.source            result
);

  logic       mode;
  logic       in_ready;
  psar_cmd_t  cmd;
  psar_stat_t stat;

  // mode register
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr[APB_ADDR_W-1] == REG_MODE_IDX) begin
      mode <= pwdata[0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[APB_ADDR_W-1] == REG_MODE_IDX) ? APB_DATA_W'(mode) : '0;

  assign request.ready = in_ready;

  psar_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (request.valid),
    .in_ready (in_ready),
    .mode     (mode),
    .stat     (stat),
    .cmd      (cmd)
  );

  psar_dp #(
    .SLOTS     (SLOTS),
    .PRIO_BITS (PRIO_BITS),
    .TIME_BITS (TIME_BITS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .command         (request.command),
    .target_slot     (request.target_slot),
    .new_priority    (request.new_priority),
    .new_arrival     (request.new_arrival),
    .out_valid       (result.valid),
    .out_ready       (result.ready),
    .chosen_slot     (result.chosen_slot),
    .chosen_priority (result.chosen_priority),
    .status          (result.status)
  );

endmodule
